@@ rtl/bfk_pkg.sv @@
`default_nettype none
package bfk_pkg;
   localparam int FRAC_BITS = 16;
   localparam int TAN_STAGES = 16;

   // divider geometry shared by the tangent lanes and the merge stage
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 34;
   localparam int DIV_LAT = DIV_NUM_W + 1;
   // tangent lane: CORDIC entry register, rotation stages, divider
   localparam int LANE_LAT = 1 + TAN_STAGES + DIV_LAT;

   localparam logic signed [23:0] MAX_S24 = 24'sh7FFFFF;
   localparam logic signed [23:0] MIN_S24 = -24'sh800000;
   localparam logic [23:0] MAX_U24 = 24'hFFFFFF;
   localparam logic signed [31:0] TAN_BOUND = 32'sd1073741823;

   localparam logic [1:0] ADDR_WHEELBASE = 2'd0;
   localparam logic [1:0] ADDR_STEER_LIMIT = 2'd1;
   localparam logic [1:0] ADDR_THRESHOLD = 2'd2;

   localparam logic [19:0] WHEELBASE_RESET = 20'd65536;
   localparam logic [16:0] STEER_LIMIT_RESET = 17'd51472;
   localparam logic [15:0] THRESHOLD_RESET = 16'd66;

   // atan(2^-i), 30 fractional bits, truncated
   function automatic logic signed [31:0] atan_entry(input int i);
      logic signed [31:0] r;
      begin
         case (i)
            0: r = 32'sh3243F6A8;
            1: r = 32'sh1DAC6705;
            2: r = 32'sh0FADBAFC;
            3: r = 32'sh07F56EA6;
            4: r = 32'sh03FEAB76;
            5: r = 32'sh01FFD55B;
            6: r = 32'sh00FFFAAA;
            7: r = 32'sh007FFF55;
            8: r = 32'sh003FFFEA;
            9: r = 32'sh001FFFFD;
            10: r = 32'sh000FFFFF;
            11: r = 32'sh0007FFFF;
            12: r = 32'sh0003FFFF;
            13: r = 32'sh0001FFFF;
            14: r = 32'sh0000FFFF;
            15: r = 32'sh00007FFF;
            16: r = 32'sh00003FFF;
            17: r = 32'sh00001FFF;
            18: r = 32'sh00000FFF;
            19: r = 32'sh000007FF;
            20: r = 32'sh000003FF;
            21: r = 32'sh000001FF;
            22: r = 32'sh000000FF;
            default: r = 32'sh0000007F;
         endcase
         return r;
      end
   endfunction

   typedef struct packed {
      logic signed [23:0] speed;
      logic               dual;
      logic [19:0]        wheelbase;
      logic [15:0]        thresh;
   } side_type;
endpackage
`default_nettype wire

@@ rtl/bicycle_forward_kinematics.sv @@
`default_nettype none
// Pipeline from the start transfer to rsp_valid: tangent lanes (entry register,
// 16 CORDIC stages, divider), then merge (two stages, dividers, output register).
// Throughput: one command per cycle; busy stays low, nothing holds results off.
// Reset: synchronous active high; clears the pipeline valids and restores registers.
module bicycle_forward_kinematics (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic signed [23:0] req_speed,
   input  wire logic signed [18:0] req_front_steer,
   input  wire logic signed [18:0] req_rear_steer,
   input  wire logic         req_dual_mode,
   output logic              rsp_valid,
   output logic signed [23:0] rsp_body_vx,
   output logic signed [23:0] rsp_body_vy,
   output logic signed [23:0] rsp_yaw_rate,
   output logic signed [23:0] rsp_path_curvature,
   output logic [23:0]       rsp_turn_radius,
   output logic              rsp_straight,
   output logic              rsp_saturated,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [3:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import bfk_pkg::*;

   logic [19:0] wheelbase_ff;
   logic [16:0] limit_ff;
   logic [15:0] thresh_ff;
   logic        wr;

   assign pready = 1'b1;
   assign busy = 1'b0;
   assign wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheelbase_ff <= WHEELBASE_RESET;
         limit_ff <= STEER_LIMIT_RESET;
         thresh_ff <= THRESHOLD_RESET;
      end else if (wr && paddr[1:0] == 2'b00) begin
         unique case (paddr[3:2])
            ADDR_WHEELBASE: wheelbase_ff <= pwdata[19:0];
            ADDR_STEER_LIMIT: limit_ff <= pwdata[16:0];
            ADDR_THRESHOLD: thresh_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         ADDR_WHEELBASE: prdata = 32'(wheelbase_ff);
         ADDR_STEER_LIMIT: prdata = 32'(limit_ff);
         ADDR_THRESHOLD: prdata = 32'(thresh_ff);
         default: prdata = '0;
      endcase
   end

   logic go;
   assign go = start && !busy;

   // side info travels alongside the lanes in a delay line matching their latency
   side_type side_ff [LANE_LAT];
   side_type side_now;
   always_comb begin
      side_now.speed = req_speed;
      side_now.dual = req_dual_mode;
      side_now.wheelbase = wheelbase_ff;
      side_now.thresh = thresh_ff;
   end
   always_ff @(posedge clock) begin
      side_ff[0] <= side_now;
      for (int i = 1; i < LANE_LAT; i++) side_ff[i] <= side_ff[i-1];
   end

   logic vf, vr;
   logic signed [31:0] tf, tr;

   bfk_tan_lane u_front (
      .clock(clock), .reset(reset), .in_valid(go), .in_angle(req_front_steer),
      .in_limit(limit_ff), .out_valid(vf), .out_tan(tf));
   bfk_tan_lane u_rear (
      .clock(clock), .reset(reset), .in_valid(go), .in_angle(req_rear_steer),
      .in_limit(limit_ff), .out_valid(vr), .out_tan(tr));

   logic mv;
   bfk_merge u_merge (
      .clock(clock), .reset(reset), .in_valid(vf && vr),
      .tan_f(tf), .tan_r(tr), .side(side_ff[LANE_LAT-1]),
      .out_valid(mv), .body_vx(rsp_body_vx), .body_vy(rsp_body_vy),
      .yaw_rate(rsp_yaw_rate), .path_curvature(rsp_path_curvature),
      .turn_radius(rsp_turn_radius), .straight(rsp_straight),
      .saturated(rsp_saturated));
   assign rsp_valid = mv;
endmodule
`default_nettype wire

@@ rtl/bfk_divider.sv @@
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// Quotient is truncated (toward zero once sign is reapplied by the caller).
// Callers carry their side data in delay lines matching the divider pipeline.
module bfk_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [bfk_pkg::DIV_NUM_W-1:0] in_num,
   input  wire logic [bfk_pkg::DIV_DEN_W-1:0] in_den,
   output logic                               out_valid,
   output logic [bfk_pkg::DIV_NUM_W-1:0]      out_quo
);
   import bfk_pkg::*;

   localparam int NW = DIV_NUM_W;
   localparam int DW = DIV_DEN_W;

   logic [NW:0]       vld_ff;
   logic [NW-1:0]     num_ff [NW+1];
   logic [DW:0]       rem_ff [NW+1];
   logic [DW-1:0]     den_ff [NW+1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[NW-1:0], in_valid};
      num_ff[0] <= in_num;
      rem_ff[0] <= '0;
      den_ff[0] <= in_den;
   end

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [DW+1:0] trial;
      logic [DW:0]   shifted;
      always_comb begin
         shifted = {rem_ff[s][DW-1:0], num_ff[s][NW-1]};
         trial = {1'b0, shifted} - {2'b00, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         den_ff[s+1] <= den_ff[s];
         if (!trial[DW+1]) begin
            rem_ff[s+1] <= trial[DW:0];
            num_ff[s+1] <= {num_ff[s][NW-2:0], 1'b1};
         end else begin
            rem_ff[s+1] <= shifted;
            num_ff[s+1] <= {num_ff[s][NW-2:0], 1'b0};
         end
      end
   end

   assign out_valid = vld_ff[NW];
   assign out_quo = num_ff[NW];
endmodule
`default_nettype wire

@@ rtl/bfk_tan_lane.sv @@
`default_nettype none
// One tangent lane: clamp, pipelined CORDIC rotation, then y<<F / x divide.
module bfk_tan_lane (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic signed [18:0]  in_angle,
   input  wire logic [16:0]         in_limit,
   output logic                     out_valid,
   output logic signed [31:0]       out_tan
);
   import bfk_pkg::*;

   localparam int S = TAN_STAGES;
   localparam int NW = DIV_NUM_W;

   logic signed [18:0] lim_s;
   logic signed [18:0] clamped;

   always_comb begin
      lim_s = $signed({2'b00, in_limit});
      if (in_angle > lim_s) clamped = lim_s;
      else if (in_angle < -lim_s) clamped = -lim_s;
      else clamped = in_angle;
   end

   logic               cv_ff [S+1];
   logic signed [33:0] x_ff [S+1];
   logic signed [33:0] y_ff [S+1];
   logic signed [33:0] z_ff [S+1];

   always_ff @(posedge clock) begin
      if (reset) cv_ff[0] <= 1'b0;
      else cv_ff[0] <= in_valid;
      x_ff[0] <= 34'sd1073741824;
      y_ff[0] <= '0;
      z_ff[0] <= 34'(signed'(clamped)) <<< (30 - FRAC_BITS);
   end

   for (genvar i = 0; i < S; i++) begin : g_cordic
      logic signed [33:0] dx, dy, at;
      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         at = 34'(atan_entry(i));
      end
      always_ff @(posedge clock) begin
         if (reset) cv_ff[i+1] <= 1'b0;
         else cv_ff[i+1] <= cv_ff[i];
         if (!z_ff[i][33]) begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            z_ff[i+1] <= z_ff[i] - at;
         end else begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            z_ff[i+1] <= z_ff[i] + at;
         end
      end
   end

   logic signed [33:0] xs, ys;
   logic [33:0]        yabs;
   logic [NW-1:0]      num;
   logic [2:0]         tag_in; // {x<=0, y>=0, y negative}
   logic               dv;
   logic [NW-1:0]      quo;
   logic [2:0]         tag_out;
   logic [2:0]         tag_ff [DIV_LAT];

   always_comb begin
      xs = x_ff[S];
      ys = y_ff[S];
      yabs = ys[33] ? 34'(-ys) : 34'(ys);
      num = NW'(yabs) << FRAC_BITS;
      tag_in = {(xs[33] || xs == 0), !ys[33], ys[33]};
   end

   bfk_divider u_div (
      .clock(clock), .reset(reset),
      .in_valid(cv_ff[S]), .in_num(num),
      .in_den((xs[33] || xs == 0) ? 34'd1 : 34'(xs)),
      .out_valid(dv), .out_quo(quo)
   );

   // sign and bound flags ride beside the divider
   always_ff @(posedge clock) begin
      tag_ff[0] <= tag_in;
      for (int i = 1; i < DIV_LAT; i++) tag_ff[i] <= tag_ff[i-1];
   end
   assign tag_out = tag_ff[DIV_LAT-1];

   logic [NW-1:0] bnd;
   logic [31:0]   mag;
   always_comb begin
      bnd = NW'(TAN_BOUND);
      mag = (quo > bnd) ? 32'(TAN_BOUND) : quo[31:0];
      if (tag_out[2]) out_tan = tag_out[1] ? TAN_BOUND : -TAN_BOUND;
      else out_tan = tag_out[0] ? -$signed(mag) : $signed(mag);
   end
   assign out_valid = dv;
endmodule
`default_nettype wire

@@ rtl/bfk_merge.sv @@
`default_nettype none
// Combines front and rear tangents: products, then three divides, saturation.
module bfk_merge (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic signed [31:0] tan_f,
   input  wire logic signed [31:0] tan_r,
   input  wire bfk_pkg::side_type  side,
   output logic                    out_valid,
   output logic signed [23:0]      body_vx,
   output logic signed [23:0]      body_vy,
   output logic signed [23:0]      yaw_rate,
   output logic signed [23:0]      path_curvature,
   output logic [23:0]             turn_radius,
   output logic                    straight,
   output logic                    saturated
);
   import bfk_pkg::*;

   localparam int NW = DIV_NUM_W;

   // stage A: difference and sum of the tangents
   logic               va_ff;
   logic signed [32:0] dif_ff, sum_ff;
   logic signed [31:0] tf_ff;
   side_type           sa_ff;
   side_type           side_fix;
   logic signed [32:0] tr_eff;

   always_comb tr_eff = side.dual ? 33'(tan_r) : 33'sd0;

   // zero wheelbase acts as one
   always_comb begin
      side_fix = side;
      if (side.wheelbase == '0) side_fix.wheelbase = 20'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else va_ff <= in_valid;
      dif_ff <= 33'(tan_f) - tr_eff;
      sum_ff <= 33'(tan_f) + tr_eff;
      tf_ff <= tan_f;
      sa_ff <= side_fix;
   end

   // stage B: products (24x33)
   logic               vb_ff;
   logic signed [56:0] pyaw_ff, pvy_ff;
   logic signed [31:0] tfb_ff;
   side_type           sb_ff;
   logic               slow_b_ff;
   logic [23:0]        absv;

   always_comb absv = sa_ff.speed[23] ? 24'(-sa_ff.speed) : 24'(sa_ff.speed);

   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else vb_ff <= va_ff;
      pyaw_ff <= 57'(sa_ff.speed) * 57'(dif_ff);
      pvy_ff <= 57'(sa_ff.speed) * 57'(sum_ff);
      tfb_ff <= tf_ff;
      sb_ff <= sa_ff;
      slow_b_ff <= absv < 24'(sa_ff.thresh);
   end

   // vy divide by 2^(F+1) truncating toward zero
   logic [56:0] pvy_abs, pyaw_abs;
   logic [31:0] tf_abs;
   logic signed [56:0] vy_q;
   always_comb begin
      pvy_abs = pvy_ff[56] ? 57'(-pvy_ff) : 57'(pvy_ff);
      pyaw_abs = pyaw_ff[56] ? 57'(-pyaw_ff) : 57'(pyaw_ff);
      tf_abs = tfb_ff[31] ? 32'(-tfb_ff) : 32'(tfb_ff);
      vy_q = pvy_ff[56] ? -$signed(pvy_abs >> (FRAC_BITS + 1))
                        : $signed(pvy_abs >> (FRAC_BITS + 1));
   end

   // tag: speed, vy quotient (clipped later), flags
   typedef struct packed {
      logic signed [23:0] speed;
      logic signed [56:0] vy;
      logic               yaw_neg;
      logic               curv_neg;
      logic               slow;
      logic               dual;
      logic               strt;
   } tag_type;

   tag_type tag_in, tag_d;
   tag_type tag_ff [DIV_LAT];
   logic [NW-1:0] q_yaw, q_curv, q_rad;
   logic dv_y, dv_c, dv_r;

   always_comb begin
      tag_in.speed = sb_ff.speed;
      tag_in.vy = vy_q;
      tag_in.yaw_neg = pyaw_ff[56];
      tag_in.curv_neg = tfb_ff[31];
      tag_in.slow = slow_b_ff;
      tag_in.dual = sb_ff.dual;
      tag_in.strt = (tf_abs < 32'(sb_ff.thresh)) || (tf_abs == 0);
   end

   bfk_divider u_yaw (
      .clock(clock), .reset(reset), .in_valid(vb_ff),
      .in_num(NW'(pyaw_abs)), .in_den(34'(sb_ff.wheelbase)),
      .out_valid(dv_y), .out_quo(q_yaw));
   bfk_divider u_curv (
      .clock(clock), .reset(reset), .in_valid(vb_ff),
      .in_num(NW'(tf_abs) << FRAC_BITS), .in_den(34'(sb_ff.wheelbase)),
      .out_valid(dv_c), .out_quo(q_curv));
   bfk_divider u_rad (
      .clock(clock), .reset(reset), .in_valid(vb_ff),
      .in_num(NW'(sb_ff.wheelbase) << FRAC_BITS),
      .in_den(tf_abs == 0 ? 34'd1 : 34'(tf_abs)),
      .out_valid(dv_r), .out_quo(q_rad));

   // side data delayed to line up with the quotients
   always_ff @(posedge clock) begin
      tag_ff[0] <= tag_in;
      for (int i = 1; i < DIV_LAT; i++) tag_ff[i] <= tag_ff[i-1];
   end
   assign tag_d = tag_ff[DIV_LAT-1];

   // final clip and register
   logic signed [23:0] vy_o, yaw_o, curv_o;
   logic [23:0]        rad_o;
   logic               s_vy, s_yaw, s_curv, s_rad;
   logic signed [NW:0] yaw_s, curv_s;
   logic [23:0]        max_u;

   always_comb begin
      max_u = MAX_U24;
      if (tag_d.slow) yaw_s = '0;
      else yaw_s = tag_d.yaw_neg ? -$signed({1'b0, q_yaw}) : $signed({1'b0, q_yaw});
      curv_s = tag_d.curv_neg ? -$signed({1'b0, q_curv}) : $signed({1'b0, q_curv});

      s_vy = 1'b0; vy_o = '0;
      if (!tag_d.slow && tag_d.dual) begin
         if (tag_d.vy > 57'(MAX_S24)) begin vy_o = MAX_S24; s_vy = 1'b1; end
         else if (tag_d.vy < 57'(MIN_S24)) begin vy_o = MIN_S24; s_vy = 1'b1; end
         else vy_o = tag_d.vy[23:0];
      end
      s_yaw = 1'b0;
      if (yaw_s > 65'(MAX_S24)) begin yaw_o = MAX_S24; s_yaw = 1'b1; end
      else if (yaw_s < 65'(MIN_S24)) begin yaw_o = MIN_S24; s_yaw = 1'b1; end
      else yaw_o = yaw_s[23:0];
      s_curv = 1'b0;
      if (curv_s > 65'(MAX_S24)) begin curv_o = MAX_S24; s_curv = 1'b1; end
      else if (curv_s < 65'(MIN_S24)) begin curv_o = MIN_S24; s_curv = 1'b1; end
      else curv_o = curv_s[23:0];
      s_rad = 1'b0;
      if (tag_d.strt) rad_o = max_u;
      else if (q_rad > NW'(max_u)) begin rad_o = max_u; s_rad = 1'b1; end
      else rad_o = q_rad[23:0];
   end

   logic vo_ff;
   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else vo_ff <= dv_y && dv_c && dv_r;
      body_vx <= tag_d.speed;
      body_vy <= vy_o;
      yaw_rate <= yaw_o;
      path_curvature <= curv_o;
      turn_radius <= rad_o;
      straight <= tag_d.strt;
      saturated <= s_vy | s_yaw | s_curv | s_rad;
   end
   assign out_valid = vo_ff;
endmodule
`default_nettype wire

@@ rtl/bfk_checker.sv @@
`default_nettype none
module bfk_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic busy,
   input wire logic pready,
   input wire logic rsp_valid,
   input wire logic rsp_straight,
   input wire logic [23:0] rsp_turn_radius
);
   a_ready: assert property (@(posedge clock) pready) else $error("pready low");
   a_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
   a_strt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_straight |-> rsp_turn_radius == 24'hFFFFFF)
      else $error("straight radius");
endmodule
bind bicycle_forward_kinematics bfk_checker u_chk (
   .clock(clock), .reset(reset), .busy(busy), .pready(pready),
   .rsp_valid(rsp_valid), .rsp_straight(rsp_straight),
   .rsp_turn_radius(rsp_turn_radius));
`default_nettype wire
